FILE: sv/source_text_tokenizer_top_defines.svh
// assertion macros for the tokenizer
`ifndef SOURCE_TEXT_TOKENIZER_TOP_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_DEFINES_SVH

// condition holds at every edge out of reset
`define SST_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sst_pkg.sv
package sst_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_IDENT = 3'd1;
    localparam logic [2:0] MODE_STR   = 3'd2;
    localparam logic [2:0] MODE_SLASH = 3'd3;
    localparam logic [2:0] MODE_LINE  = 3'd4;
    localparam logic [2:0] MODE_BLOCK = 3'd5;
    localparam logic [2:0] MODE_BSTAR = 3'd6;

    localparam logic [3:0] KIND_IDENT  = 4'd0;
    localparam logic [3:0] KIND_STR    = 4'd1;
    localparam logic [3:0] KIND_EQ     = 4'd2;
    localparam logic [3:0] KIND_LPAREN = 4'd3;
    localparam logic [3:0] KIND_RPAREN = 4'd4;
    localparam logic [3:0] KIND_LBRACE = 4'd5;
    localparam logic [3:0] KIND_RBRACE = 4'd6;
    localparam logic [3:0] KIND_SEMI   = 4'd7;
    localparam logic [3:0] KIND_COMMA  = 4'd8;
    localparam logic [3:0] KIND_PLUS   = 4'd9;
    localparam logic [3:0] KIND_EOF    = 4'd10;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] char_value;
        logic       has_char;
        logic       token_last;
        logic       unterminated;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step;

endpackage

FILE: sv/sst_ifs.sv
interface sst_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

interface sst_token_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [7:0] char_value;
    logic       has_char;
    logic       token_last;
    logic       unterminated;

    modport source (
        output valid, output token_kind, output char_value, output has_char,
        output token_last, output unterminated, input ready
    );
    modport sink (
        input valid, input token_kind, input char_value, input has_char,
        input token_last, input unterminated, output ready
    );
endinterface

FILE: sv/source_text_tokenizer_top.sv
// Streaming tokenizer: source bytes in on i_char_if, token items out on o_token_if.
// A byte is taken every cycle while the input does not stall; it is held in an input
// register, is classified against the scan mode in a single step of logic and its
// results (zero, one or, when a byte ends an identifier and starts another token,
// two) go into a two-entry result queue whose head drives the output. The input
// stalls only while the result queue lacks room for the items of the registered byte.
`include "source_text_tokenizer_top_defines.svh"

module source_text_tokenizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sst_char_if.sink    i_char_if,
    sst_token_if.source o_token_if
);

    logic           r_valid;
    logic [7:0]     r_char;
    logic           r_end;
    logic [2:0]     r_mode;
    logic [2:0]     n_mode;
    sst_pkg::t_step w_step;
    logic [1:0]     w_free;
    logic [1:0]     w_cnt;
    logic           w_fire;
    logic           w_take;

    assign w_fire          = r_valid && (w_step.count <= w_free);
    assign i_char_if.ready = !r_valid || w_fire;
    assign w_take          = i_char_if.valid && i_char_if.ready;

    sst_lex u_lex (
        .i_mode      (r_mode),
        .i_char      (r_char),
        .i_end       (r_end),
        .o_next_mode (n_mode),
        .o_step      (w_step)
    );

    sst_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire),
        .i_step  (w_step),
        .o_free  (w_free),
        .o_cnt   (w_cnt),
        .o_tok   (o_token_if)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mode  <= sst_pkg::MODE_IDLE;
        end else begin
            if (w_take) begin
                r_valid <= 1'b1;
            end else if (w_fire) begin
                r_valid <= 1'b0;
            end
            if (w_fire) begin
                r_mode <= n_mode;
            end
        end
        if (w_take) begin
            r_char <= i_char_if.char_in;
            r_end  <= i_char_if.end_of_input;
        end
    end

    `SST_ASSERT_ALWAYS(a_queue_bound, w_cnt <= 2'(sst_pkg::QUEUE_DEPTH), "result queue overflow")
    `SST_ASSERT_ALWAYS(a_fire_fits, !w_fire || (w_step.count <= w_free), "items pushed without room")
    `SST_ASSERT_NEXT(a_take_holds, w_take, r_valid, "accepted byte lost from input register")
    `SST_ASSERT_NEXT(a_stall_mode, r_valid && !w_fire, r_mode == $past(r_mode), "mode moved on stall")

endmodule

FILE: sv/sst_lex.sv
module sst_lex (
    input  logic [2:0]     i_mode,
    input  logic [7:0]     i_char,
    input  logic           i_end,
    output logic [2:0]     o_next_mode,
    output sst_pkg::t_step o_step
);

    typedef struct packed {
        logic              emit;
        sst_pkg::t_result  res;
        logic [2:0]        mode;
    } t_idle;

    function automatic t_idle idle_byte(input logic [7:0] c, input logic eof);
        t_idle r;
        r.emit = 1'b0;
        r.res  = '0;
        r.mode = sst_pkg::MODE_IDLE;
        if (eof) begin
            r.emit = 1'b1;
            r.res.token_kind = sst_pkg::KIND_EOF;
            r.res.token_last = 1'b1;
        end else if (c inside {sst_pkg::CH_SPACE, sst_pkg::CH_LF, sst_pkg::CH_CR,
                               sst_pkg::CH_TAB}) begin
            r.emit = 1'b0;
        end else if (c == sst_pkg::CH_SLASH) begin
            r.mode = sst_pkg::MODE_SLASH;
        end else if (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
            r.emit = 1'b1;
            r.res.token_kind = sst_pkg::KIND_IDENT;
            r.res.char_value = c;
            r.res.has_char   = 1'b1;
            r.mode = sst_pkg::MODE_IDENT;
        end else if (c == sst_pkg::CH_QUOTE) begin
            r.mode = sst_pkg::MODE_STR;
        end else begin
            r.emit = 1'b1;
            r.res.char_value = c;
            r.res.has_char   = 1'b1;
            r.res.token_last = 1'b1;
            case (c)
                sst_pkg::CH_EQ:     r.res.token_kind = sst_pkg::KIND_EQ;
                sst_pkg::CH_LPAREN: r.res.token_kind = sst_pkg::KIND_LPAREN;
                sst_pkg::CH_RPAREN: r.res.token_kind = sst_pkg::KIND_RPAREN;
                sst_pkg::CH_LBRACE: r.res.token_kind = sst_pkg::KIND_LBRACE;
                sst_pkg::CH_RBRACE: r.res.token_kind = sst_pkg::KIND_RBRACE;
                sst_pkg::CH_SEMI:   r.res.token_kind = sst_pkg::KIND_SEMI;
                sst_pkg::CH_COMMA:  r.res.token_kind = sst_pkg::KIND_COMMA;
                sst_pkg::CH_PLUS:   r.res.token_kind = sst_pkg::KIND_PLUS;
                default: begin
                    // unknown byte is dropped
                    r.emit = 1'b0;
                    r.res  = '0;
                end
            endcase
        end
        return r;
    endfunction

    logic  w_eof;
    logic  w_alnum;
    t_idle w_idle;

    assign w_eof   = i_end || (i_char == sst_pkg::CH_NUL);
    assign w_alnum = i_char inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    assign w_idle  = idle_byte(i_char, w_eof);

    always_comb begin
        o_next_mode  = i_mode;
        o_step       = '0;
        case (i_mode)
            sst_pkg::MODE_IDENT: begin
                if (!w_eof && w_alnum) begin
                    o_step.count = 2'd1;
                    o_step.res0.token_kind = sst_pkg::KIND_IDENT;
                    o_step.res0.char_value = i_char;
                    o_step.res0.has_char   = 1'b1;
                end else begin
                    // closing item, then the byte as in idle
                    o_step.count = 2'd1 + {1'b0, w_idle.emit};
                    o_step.res0.token_kind = sst_pkg::KIND_IDENT;
                    o_step.res0.token_last = 1'b1;
                    o_step.res1  = w_idle.res;
                    o_next_mode  = w_idle.mode;
                end
            end
            sst_pkg::MODE_STR: begin
                o_step.count = 2'd1;
                if (w_eof) begin
                    o_step.res0.token_kind   = sst_pkg::KIND_EOF;
                    o_step.res0.token_last   = 1'b1;
                    o_step.res0.unterminated = 1'b1;
                    o_next_mode = sst_pkg::MODE_IDLE;
                end else if (i_char == sst_pkg::CH_QUOTE) begin
                    o_step.res0.token_kind = sst_pkg::KIND_STR;
                    o_step.res0.token_last = 1'b1;
                    o_next_mode = sst_pkg::MODE_IDLE;
                end else begin
                    o_step.res0.token_kind = sst_pkg::KIND_STR;
                    o_step.res0.char_value = i_char;
                    o_step.res0.has_char   = 1'b1;
                end
            end
            sst_pkg::MODE_SLASH: begin
                if (!w_eof && i_char == sst_pkg::CH_SLASH) begin
                    o_next_mode = sst_pkg::MODE_LINE;
                end else if (!w_eof && i_char == sst_pkg::CH_STAR) begin
                    o_next_mode = sst_pkg::MODE_BLOCK;
                end else begin
                    o_step.count = {1'b0, w_idle.emit};
                    o_step.res0  = w_idle.res;
                    o_next_mode  = w_idle.mode;
                end
            end
            sst_pkg::MODE_LINE: begin
                if (w_eof) begin
                    o_step.count = {1'b0, w_idle.emit};
                    o_step.res0  = w_idle.res;
                    o_next_mode  = w_idle.mode;
                end else if (i_char == sst_pkg::CH_LF) begin
                    o_next_mode = sst_pkg::MODE_IDLE;
                end
            end
            sst_pkg::MODE_BLOCK: begin
                if (w_eof) begin
                    o_step.count = {1'b0, w_idle.emit};
                    o_step.res0  = w_idle.res;
                    o_next_mode  = w_idle.mode;
                end else if (i_char == sst_pkg::CH_STAR) begin
                    o_next_mode = sst_pkg::MODE_BSTAR;
                end
            end
            sst_pkg::MODE_BSTAR: begin
                if (w_eof) begin
                    o_step.count = {1'b0, w_idle.emit};
                    o_step.res0  = w_idle.res;
                    o_next_mode  = w_idle.mode;
                end else if (i_char == sst_pkg::CH_SLASH) begin
                    o_next_mode = sst_pkg::MODE_IDLE;
                end else if (i_char != sst_pkg::CH_STAR) begin
                    o_next_mode = sst_pkg::MODE_BLOCK;
                end
            end
            default: begin
                o_step.count = {1'b0, w_idle.emit};
                o_step.res0  = w_idle.res;
                o_next_mode  = w_idle.mode;
            end
        endcase
    end

endmodule

FILE: sv/sst_outq.sv
module sst_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sst_pkg::t_step     i_step,
    output logic [1:0]         o_free,
    output logic [1:0]         o_cnt,
    sst_token_if.source        o_tok
);

    sst_pkg::t_result r_slot [0:1];
    sst_pkg::t_result n_slot [0:1];
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic [1:0]       w_base;
    logic             w_pop;

    assign w_pop  = o_tok.valid && o_tok.ready;
    assign o_free = 2'(sst_pkg::QUEUE_DEPTH) - r_cnt + {1'b0, w_pop};
    assign o_cnt  = r_cnt;

    always_comb begin
        n_slot = r_slot;
        w_base = r_cnt;
        if (w_pop) begin
            n_slot[0] = r_slot[1];
            w_base    = r_cnt - 2'd1;
        end
        n_cnt = w_base;
        if (i_push) begin
            if (i_step.count != 2'd0) begin
                n_slot[w_base[0]] = i_step.res0;
            end
            if (i_step.count == 2'd2) begin
                n_slot[1] = i_step.res1;
            end
            n_cnt = w_base + i_step.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_slot <= n_slot;
    end

    assign o_tok.valid        = (r_cnt != 2'd0);
    assign o_tok.token_kind   = r_slot[0].token_kind;
    assign o_tok.char_value   = r_slot[0].char_value;
    assign o_tok.has_char     = r_slot[0].has_char;
    assign o_tok.token_last   = r_slot[0].token_last;
    assign o_tok.unterminated = r_slot[0].unterminated;

endmodule

FILE: bench/token_stream_checker.sv
`timescale 1ns / 100ps

module token_stream_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sst_char_if   i_char_if,
    sst_token_if  i_token_if,
    output int    o_fail_count,
    output int    o_pending
);

    logic [2:0]       lex_mode;
    sst_pkg::t_result expected_tokens[$];
    int               mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_error(input string msg);
        $display("tokenizer mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic bit is_word_char(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c inside {sst_pkg::CH_SPACE, sst_pkg::CH_TAB, sst_pkg::CH_CR,
                         sst_pkg::CH_LF};
    endfunction

    // eof here means the byte is not a one-item token
    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        case (c)
            sst_pkg::CH_EQ:     return sst_pkg::KIND_EQ;
            sst_pkg::CH_LPAREN: return sst_pkg::KIND_LPAREN;
            sst_pkg::CH_RPAREN: return sst_pkg::KIND_RPAREN;
            sst_pkg::CH_LBRACE: return sst_pkg::KIND_LBRACE;
            sst_pkg::CH_RBRACE: return sst_pkg::KIND_RBRACE;
            sst_pkg::CH_SEMI:   return sst_pkg::KIND_SEMI;
            sst_pkg::CH_COMMA:  return sst_pkg::KIND_COMMA;
            sst_pkg::CH_PLUS:   return sst_pkg::KIND_PLUS;
            default:            return sst_pkg::KIND_EOF;
        endcase
    endfunction

    function automatic void push_token(input logic [3:0] kind, input logic [7:0] ch,
                                       input logic has, input logic last,
                                       input logic unterm);
        sst_pkg::t_result r;
        r.token_kind   = kind;
        r.char_value   = ch;
        r.has_char     = has;
        r.token_last   = last;
        r.unterminated = unterm;
        expected_tokens.push_back(r);
    endfunction

    function automatic void scan_idle(input logic [7:0] c, input logic eof);
        logic [3:0] kind;
        kind = punct_kind(c);
        lex_mode = sst_pkg::MODE_IDLE;
        if (eof) begin
            push_token(sst_pkg::KIND_EOF, sst_pkg::CH_NUL, 1'b0, 1'b1, 1'b0);
        end else if (c == sst_pkg::CH_SLASH) begin
            lex_mode = sst_pkg::MODE_SLASH;
        end else if (is_word_char(c)) begin
            push_token(sst_pkg::KIND_IDENT, c, 1'b1, 1'b0, 1'b0);
            lex_mode = sst_pkg::MODE_IDENT;
        end else if (c == sst_pkg::CH_QUOTE) begin
            lex_mode = sst_pkg::MODE_STR;
        end else if (!is_blank(c) && kind != sst_pkg::KIND_EOF) begin
            push_token(kind, c, 1'b1, 1'b1, 1'b0);
        end
    endfunction

    function automatic void scan_byte(input logic [7:0] c, input logic eoi);
        logic eof;
        eof = eoi || c == sst_pkg::CH_NUL;
        case (lex_mode)
            sst_pkg::MODE_IDENT: begin
                if (!eof && is_word_char(c)) begin
                    push_token(sst_pkg::KIND_IDENT, c, 1'b1, 1'b0, 1'b0);
                end else begin
                    push_token(sst_pkg::KIND_IDENT, sst_pkg::CH_NUL, 1'b0, 1'b1, 1'b0);
                    scan_idle(c, eof);
                end
            end
            sst_pkg::MODE_STR: begin
                if (eof) begin
                    push_token(sst_pkg::KIND_EOF, sst_pkg::CH_NUL, 1'b0, 1'b1, 1'b1);
                    lex_mode = sst_pkg::MODE_IDLE;
                end else if (c == sst_pkg::CH_QUOTE) begin
                    push_token(sst_pkg::KIND_STR, sst_pkg::CH_NUL, 1'b0, 1'b1, 1'b0);
                    lex_mode = sst_pkg::MODE_IDLE;
                end else begin
                    push_token(sst_pkg::KIND_STR, c, 1'b1, 1'b0, 1'b0);
                end
            end
            sst_pkg::MODE_SLASH: begin
                if (!eof && c == sst_pkg::CH_SLASH) lex_mode = sst_pkg::MODE_LINE;
                else if (!eof && c == sst_pkg::CH_STAR) lex_mode = sst_pkg::MODE_BLOCK;
                else scan_idle(c, eof);
            end
            sst_pkg::MODE_LINE: begin
                if (eof) scan_idle(c, eof);
                else if (c == sst_pkg::CH_LF) lex_mode = sst_pkg::MODE_IDLE;
            end
            sst_pkg::MODE_BLOCK: begin
                if (eof) scan_idle(c, eof);
                else if (c == sst_pkg::CH_STAR) lex_mode = sst_pkg::MODE_BSTAR;
            end
            sst_pkg::MODE_BSTAR: begin
                if (eof) scan_idle(c, eof);
                else if (c == sst_pkg::CH_SLASH) lex_mode = sst_pkg::MODE_IDLE;
                else if (c != sst_pkg::CH_STAR) lex_mode = sst_pkg::MODE_BLOCK;
            end
            default: begin
                scan_idle(c, eof);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        sst_pkg::t_result got;
        sst_pkg::t_result want;
        if (!i_rst_n) begin
            lex_mode = sst_pkg::MODE_IDLE;
            expected_tokens.delete();
            o_pending <= 0;
        end else begin
            if (i_char_if.valid === 1'b1 && i_char_if.ready === 1'b1) begin
                scan_byte(i_char_if.char_in, i_char_if.end_of_input);
            end
            if (i_token_if.valid === 1'b1 && i_token_if.ready === 1'b1) begin
                got.token_kind   = i_token_if.token_kind;
                got.char_value   = i_token_if.char_value;
                got.has_char     = i_token_if.has_char;
                got.token_last   = i_token_if.token_last;
                got.unterminated = i_token_if.unterminated;
                if (expected_tokens.size() == 0) begin
                    report_error($sformatf("unexpected item kind %0d char %02h",
                                           got.token_kind, got.char_value));
                end else begin
                    want = expected_tokens.pop_front();
                    if (got.token_kind !== want.token_kind)
                        report_error($sformatf("token_kind expected %0d got %0d",
                                               want.token_kind, got.token_kind));
                    if (got.char_value !== want.char_value)
                        report_error($sformatf("char_value expected %02h got %02h",
                                               want.char_value, got.char_value));
                    if (got.has_char !== want.has_char)
                        report_error($sformatf("has_char expected %0b got %0b",
                                               want.has_char, got.has_char));
                    if (got.token_last !== want.token_last)
                        report_error($sformatf("token_last expected %0b got %0b",
                                               want.token_last, got.token_last));
                    if (got.unterminated !== want.unterminated)
                        report_error($sformatf("unterminated expected %0b got %0b",
                                               want.unterminated, got.unterminated));
                end
            end
            o_pending <= expected_tokens.size();
        end
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int ITEM_TARGET = 1950;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic allow_idle;
    int   fail_count;
    int   pending;
    int   items_sent = 0;
    int   cycle_count = 0;

    sst_char_if  char_bus ();
    sst_token_if token_bus ();

    source_text_tokenizer_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_char_if  (char_bus),
        .o_token_if (token_bus)
    );

    token_stream_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_char_if    (char_bus),
        .i_token_if   (token_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            token_bus.ready <= 1'b0;
        end else begin
            token_bus.ready <= !allow_idle || $urandom_range(0, 99) >= 15;
        end
    end

    task automatic send_item(input logic [7:0] ch, input logic eoi);
        while (allow_idle && $urandom_range(0, 99) < 15) begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_bus.valid        <= 1'b1;
        char_bus.char_in      <= ch;
        char_bus.end_of_input <= eoi;
        @(posedge clk);
        while (char_bus.ready !== 1'b1) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        char_bus.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [7:0] pick_word_char();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) return 8'("0" + r);
        if (r < 36) return 8'("A" + r - 10);
        return 8'("a" + r - 36);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return sst_pkg::CH_SPACE;
            1:       return sst_pkg::CH_TAB;
            2:       return sst_pkg::CH_CR;
            default: return sst_pkg::CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(0, 7))
            0:       return sst_pkg::CH_EQ;
            1:       return sst_pkg::CH_LPAREN;
            2:       return sst_pkg::CH_RPAREN;
            3:       return sst_pkg::CH_LBRACE;
            4:       return sst_pkg::CH_RBRACE;
            5:       return sst_pkg::CH_SEMI;
            6:       return sst_pkg::CH_COMMA;
            default: return sst_pkg::CH_PLUS;
        endcase
    endfunction

    initial begin
        logic [8:0] directed_seq[$];
        logic [7:0] ch;
        int         len;
        int         sel;
        bit         paused;

        paused                = 1'b0;
        rst_n                 <= 1'b0;
        allow_idle            <= 1'b1;
        char_bus.valid        <= 1'b0;
        char_bus.char_in      <= sst_pkg::CH_NUL;
        char_bus.end_of_input <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identifier closed by a token, all one-item tokens, string, block comment
        // with a slash inside, lone slash, dropped byte, line comment,
        // unterminated string, byte zero as end
        directed_seq = '{
            {1'b0, 8'("Z")}, {1'b0, 8'("9")}, {1'b0, sst_pkg::CH_EQ},
            {1'b0, sst_pkg::CH_LPAREN}, {1'b0, sst_pkg::CH_RPAREN},
            {1'b0, sst_pkg::CH_LBRACE}, {1'b0, sst_pkg::CH_RBRACE},
            {1'b0, sst_pkg::CH_SEMI}, {1'b0, sst_pkg::CH_COMMA},
            {1'b0, sst_pkg::CH_PLUS},
            {1'b0, sst_pkg::CH_QUOTE}, {1'b0, 8'hFF}, {1'b0, sst_pkg::CH_QUOTE},
            {1'b0, sst_pkg::CH_SLASH}, {1'b0, sst_pkg::CH_STAR},
            {1'b0, sst_pkg::CH_SLASH}, {1'b0, sst_pkg::CH_STAR},
            {1'b0, sst_pkg::CH_SLASH},
            {1'b0, sst_pkg::CH_SLASH}, {1'b0, 8'("a")}, {1'b0, 8'h80},
            {1'b0, sst_pkg::CH_SLASH}, {1'b0, sst_pkg::CH_SLASH},
            {1'b0, sst_pkg::CH_LF},
            {1'b0, sst_pkg::CH_QUOTE}, {1'b0, 8'("s")}, {1'b1, 8'hA5},
            {1'b0, sst_pkg::CH_NUL}
        };
        foreach (directed_seq[i]) send_item(directed_seq[i][7:0], directed_seq[i][8]);
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            allow_idle <= !(items_sent >= 900 && items_sent < 1400);
            if (!paused && items_sent >= 1200) begin
                wait_drained();
                paused = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                len = $urandom_range(1, 10);
                repeat (len) send_item(pick_word_char(), 1'b0);
            end else if (sel < 40) begin
                send_item(pick_punct(), 1'b0);
            end else if (sel < 50) begin
                len = $urandom_range(1, 3);
                repeat (len) send_item(pick_blank(), 1'b0);
            end else if (sel < 60) begin
                send_item(sst_pkg::CH_QUOTE, 1'b0);
                len = $urandom_range(0, 8);
                repeat (len) begin
                    do ch = 8'($urandom_range(1, 255)); while (ch == sst_pkg::CH_QUOTE);
                    send_item(ch, 1'b0);
                end
                if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
                else send_item(sst_pkg::CH_QUOTE, 1'b0);
            end else if (sel < 67) begin
                send_item(sst_pkg::CH_SLASH, 1'b0);
                send_item(sst_pkg::CH_SLASH, 1'b0);
                len = $urandom_range(0, 8);
                repeat (len) begin
                    do ch = 8'($urandom_range(1, 255)); while (ch == sst_pkg::CH_LF);
                    send_item(ch, 1'b0);
                end
                send_item(sst_pkg::CH_LF, 1'b0);
            end else if (sel < 74) begin
                send_item(sst_pkg::CH_SLASH, 1'b0);
                send_item(sst_pkg::CH_STAR, 1'b0);
                len = $urandom_range(0, 8);
                repeat (len) begin
                    case ($urandom_range(0, 3))
                        0:       ch = sst_pkg::CH_STAR;
                        1:       ch = sst_pkg::CH_SLASH;
                        2:       ch = pick_word_char();
                        default: ch = 8'($urandom_range(1, 255));
                    endcase
                    send_item(ch, 1'b0);
                end
                send_item(sst_pkg::CH_STAR, 1'b0);
                send_item(sst_pkg::CH_SLASH, 1'b0);
            end else if (sel < 79) begin
                send_item(sst_pkg::CH_SLASH, 1'b0);
            end else if (sel < 86) begin
                if ($urandom_range(0, 1) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
                else send_item(sst_pkg::CH_NUL, 1'b0);
            end else begin
                send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
